/* rtl/core/acq_pkg.sv */
// acq_pkg: shared types and constants for the addressed command queue
// depends on nothing; used by addressed_command_queue
package acq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int NUM_TARGETS = 5;
  localparam int ENTRY_W = 12;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [2:0] MAX_INDEX = 3'd5;
  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_SET_IDLE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RES_ACCEPTED = 3'd0,
    RES_FULL     = 3'd1,
    RES_BAD_IDX  = 3'd2,
    RES_TRANSMIT = 3'd3,
    RES_COMPLETE = 3'd4,
    RES_LISTEN   = 3'd5,
    RES_STRAY    = 3'd6
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_HEAD,
    S_TX,
    S_RESP,
    S_LISTEN
  } state_t;

  // queue entry as held in the ram
  typedef struct packed {
    logic       notify;
    logic [2:0] index;
    logic [7:0] command;
  } entry_t;

endpackage

/* rtl/core/acq_ram.sv */
// acq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module acq_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/addressed_command_queue.sv */
// addressed_command_queue: command fifo in a ram with line-idle tracking
// accepted, full, bad index and stray results appear in the cycle after the transaction;
// a transmit passes S_RD_HEAD (ram read) and S_TX, which waits for a free output register;
// a response pops the head (completion if notify), then transmits the next head or listens;
// input is taken only in S_IDLE and only while the single output register is empty
// reset (synchronous, rst_n low): queue empty, head 0, line not idle, targets 0, ram not cleared
module addressed_command_queue (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // command_code[7:0], device_index[10:8], notify_wanted[11], response_kind[13:12],
  // response_value[21:14], idle_value[22], zero pad[23]
  input  logic [23:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame[15:0], done_command[23:16], done_index[26:24], done_response_kind[28:27],
  // done_response_value[36:29], zero pad[39:37]
  output logic [39:0] out_tdata,
  // result_kind[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  // control state
  acq_pkg::state_t                  state_r, state_nxt;
  logic [acq_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [acq_pkg::PTR_W-1:0]        head_r, head_nxt;
  logic                             idle_r, idle_nxt;
  logic [7:0]                       tgt_r [acq_pkg::NUM_TARGETS];

  // latched response payload
  logic [1:0]                       rkind_r, rkind_nxt;
  logic [7:0]                       rval_r, rval_nxt;

  // output register
  logic                             ovalid_r, ovalid_nxt;
  acq_pkg::res_kind_t               okind_r, okind_nxt;
  logic [15:0]                      oframe_r, oframe_nxt;
  logic [7:0]                       ocmd_r, ocmd_nxt;
  logic [2:0]                       oidx_r, oidx_nxt;
  logic [1:0]                       orkind_r, orkind_nxt;
  logic [7:0]                       orval_r, orval_nxt;
  logic                             olast_r, olast_nxt;

  // ram ports
  logic                             ram_we, ram_re;
  logic [acq_pkg::PTR_W-1:0]        ram_waddr, ram_raddr;
  acq_pkg::entry_t                  ram_wentry, ram_rentry;
  logic [acq_pkg::ENTRY_W-1:0]      ram_rdata;

  // input field views
  acq_pkg::op_t                     in_op;
  logic [7:0]                       in_cmd;
  logic [2:0]                       in_idx;
  logic                             in_ntf;
  logic [1:0]                       in_rkind;
  logic [7:0]                       in_rval;
  logic                             in_idle;

  logic                             in_fire, out_free;
  logic [acq_pkg::SUM_W-1:0]        tail_sum;
  logic [acq_pkg::PTR_W-1:0]        tail;
  logic [7:0]                       tx_addr;

  assign in_op    = acq_pkg::op_t'(in_tuser);
  assign in_cmd   = in_tdata[7:0];
  assign in_idx   = in_tdata[10:8];
  assign in_ntf   = in_tdata[11];
  assign in_rkind = in_tdata[13:12];
  assign in_rval  = in_tdata[21:14];
  assign in_idle  = in_tdata[22];

  assign in_tready = (state_r == acq_pkg::S_IDLE) && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;

  // tail slot = (head + count) mod depth, one conditional subtract
  always_comb begin
    tail_sum = acq_pkg::SUM_W'(head_r) + acq_pkg::SUM_W'(cnt_r);
    if (tail_sum >= acq_pkg::SUM_W'(acq_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - acq_pkg::SUM_W'(acq_pkg::QUEUE_DEPTH);
    end
    tail = tail_sum[acq_pkg::PTR_W-1:0];
  end

  // head entry as read back from the ram, and its bus address
  assign ram_rentry = acq_pkg::entry_t'(ram_rdata);

  always_comb begin
    if (ram_rentry.index == 3'd0 || ram_rentry.index > acq_pkg::MAX_INDEX) begin
      tx_addr = acq_pkg::BROADCAST_ADDR;
    end else begin
      tx_addr = tgt_r[ram_rentry.index - 3'd1];
    end
  end

  acq_ram #(
    .WIDTH (acq_pkg::ENTRY_W),
    .DEPTH (acq_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: next state, ram accesses and output register loads
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    idle_nxt   = idle_r;
    rkind_nxt  = rkind_r;
    rval_nxt   = rval_r;

    ovalid_nxt = ovalid_r && !out_tready;
    okind_nxt  = okind_r;
    oframe_nxt = oframe_r;
    ocmd_nxt   = ocmd_r;
    oidx_nxt   = oidx_r;
    orkind_nxt = orkind_r;
    orval_nxt  = orval_r;
    olast_nxt  = olast_r;

    ram_we     = 1'b0;
    ram_waddr  = tail;
    ram_wentry = '{notify: in_ntf, index: in_idx, command: in_cmd};
    ram_re     = 1'b0;
    ram_raddr  = head_r;

    unique case (state_r)
      acq_pkg::S_IDLE: begin
        if (in_fire) begin
          // the output register is empty here, any result loads it directly
          oframe_nxt = '0;
          ocmd_nxt   = '0;
          oidx_nxt   = '0;
          orkind_nxt = '0;
          orval_nxt  = '0;
          olast_nxt  = 1'b1;
          unique case (in_op)
            acq_pkg::OP_ENQUEUE: begin
              ovalid_nxt = 1'b1;
              if (cnt_r >= acq_pkg::DEPTH_CNT) begin
                okind_nxt = acq_pkg::RES_FULL;
              end else if (in_idx > acq_pkg::MAX_INDEX) begin
                okind_nxt = acq_pkg::RES_BAD_IDX;
              end else begin
                ram_we    = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
                okind_nxt = acq_pkg::RES_ACCEPTED;
                // line idle: head goes out once the write has landed
                if (idle_r) begin
                  olast_nxt = 1'b0;
                  state_nxt = acq_pkg::S_RD_HEAD;
                end
              end
            end
            acq_pkg::OP_RESPONSE: begin
              if (cnt_r == '0) begin
                ovalid_nxt = 1'b1;
                okind_nxt  = acq_pkg::RES_STRAY;
              end else begin
                ram_re    = 1'b1;
                rkind_nxt = in_rkind;
                rval_nxt  = in_rval;
                state_nxt = acq_pkg::S_RESP;
              end
            end
            acq_pkg::OP_SET_IDLE: begin
              idle_nxt = in_idle;
            end
            acq_pkg::OP_NONE: begin
              // ignored, no result
            end
            default: begin
            end
          endcase
        end
      end

      acq_pkg::S_RD_HEAD: begin
        ram_re    = 1'b1;
        state_nxt = acq_pkg::S_TX;
      end

      acq_pkg::S_TX: begin
        // head entry is held on the ram read port until the next read
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = acq_pkg::RES_TRANSMIT;
          oframe_nxt = {tx_addr, ram_rentry.command};
          ocmd_nxt   = '0;
          oidx_nxt   = '0;
          orkind_nxt = '0;
          orval_nxt  = '0;
          olast_nxt  = 1'b1;
          idle_nxt   = 1'b0;
          state_nxt  = acq_pkg::S_IDLE;
        end
      end

      acq_pkg::S_RESP: begin
        // pop the head; the output register is still empty here
        cnt_nxt = cnt_r - 1'b1;
        if (head_r == acq_pkg::PTR_W'(acq_pkg::QUEUE_DEPTH - 1)) begin
          head_nxt = '0;
        end else begin
          head_nxt = head_r + 1'b1;
        end
        if (ram_rentry.notify) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = acq_pkg::RES_COMPLETE;
          oframe_nxt = '0;
          ocmd_nxt   = ram_rentry.command;
          oidx_nxt   = ram_rentry.index;
          orkind_nxt = rkind_r;
          orval_nxt  = rval_r;
          olast_nxt  = 1'b0;
        end
        if (cnt_r == acq_pkg::CNT_W'(1)) begin
          state_nxt = acq_pkg::S_LISTEN;
        end else begin
          state_nxt = acq_pkg::S_RD_HEAD;
        end
      end

      acq_pkg::S_LISTEN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = acq_pkg::RES_LISTEN;
          oframe_nxt = '0;
          ocmd_nxt   = '0;
          oidx_nxt   = '0;
          orkind_nxt = '0;
          orval_nxt  = '0;
          olast_nxt  = 1'b1;
          idle_nxt   = 1'b1;
          state_nxt  = acq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = acq_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= acq_pkg::S_IDLE;
      cnt_r    <= '0;
      head_r   <= '0;
      idle_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      idle_r   <= idle_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    rkind_r  <= rkind_nxt;
    rval_r   <= rval_nxt;
    okind_r  <= okind_nxt;
    oframe_r <= oframe_nxt;
    ocmd_r   <= ocmd_nxt;
    oidx_r   <= oidx_nxt;
    orkind_r <= orkind_nxt;
    orval_r  <= orval_nxt;
    olast_r  <= olast_nxt;
  end

  // target address registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < acq_pkg::NUM_TARGETS; i++) begin
        tgt_r[i] <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < acq_pkg::NUM_TARGETS; i++) begin
        if (cfg_index == 3'(i)) begin
          tgt_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, orval_r, orkind_r, oidx_r, ocmd_r, oframe_r};

`ifndef NO_ASSERTIONS
  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= acq_pkg::DEPTH_CNT)
    else $error("queue count above depth");

  // a response on a non-empty queue pops exactly one entry
  a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == acq_pkg::OP_RESPONSE && cnt_r != '0
    |=> ##1 cnt_r == $past(cnt_r, 2) - 1'b1)
    else $error("response did not pop one entry");

  // a transmit is always the final result of its transaction
  a_tx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == acq_pkg::RES_TRANSMIT |-> out_tlast)
    else $error("transmit not marked last");

  // a delivered transmit leaves the line busy
  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == acq_pkg::RES_TRANSMIT |-> !idle_r)
    else $error("line idle after transmit");

  // a completion is always followed by a further result of the same transaction
  a_done_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == acq_pkg::RES_COMPLETE |-> !out_tlast)
    else $error("completion marked last");
`endif

endmodule
